@@ design/rau_pkg.sv @@
// Shared types and constants of the rational arithmetic unit.
// Used by rau_ctrl, rau_dp and rational_arithmetic_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

	// Default width of a result word
	localparam int WORD_BITS_DEF = 32;

	// Width of the exact intermediates (cross products and their sum)
	localparam int WIDE = 64;
	localparam int CNT_W = $clog2(WIDE);

	// Operation codes of a request
	localparam logic [2:0] K_ADD = 3'd0;
	localparam logic [2:0] K_SUB = 3'd1;
	localparam logic [2:0] K_MUL = 3'd2;
	localparam logic [2:0] K_DIV = 3'd3;
	localparam logic [2:0] K_NEG = 3'd4;
	localparam logic [2:0] K_NE  = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Multiplier steps: first cross product, second cross product, denominator
	localparam logic [1:0] MS_P = 2'd0;
	localparam logic [1:0] MS_Q = 2'd1;
	localparam logic [1:0] MS_D = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_step;
		logic       comb;
		logic       sign;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       finish;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic early_exit;
		logic is_cmp;
		logic num_zero;
		logic gcd_done;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ design/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
// A request (start high while busy is low) carries an operation and two
// fractions; one result follows, shown for a single cycle with done high,
// and must be captured then because it cannot be held off. An error case
// goes straight from the latched request to the result, the not-equal test
// ends once the cross products are combined and a zero numerator once the
// sign is split off. A full reduction uses the shared 33x33 multiplier for
// both cross products and the denominator, then a binary gcd loop that
// removes at least one bit from one of the two operands each cycle, then
// restoring division that divides numerator and denominator side by side.
// The next request may be issued in the cycle that done is high.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] first_num,
	input  wire logic [30:0]        first_den,
	input  wire logic signed [31:0] second_num,
	input  wire logic [30:0]        second_den,
	output logic                    done,
	output logic signed [31:0]      res_num,
	output logic [30:0]             res_den,
	output logic                    differs,
	output logic [1:0]              status
);

	rau_pkg::dp_cmd_t  cmd;
	rau_pkg::dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rau_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.kind       (kind),
		.first_num  (first_num),
		.first_den  (first_den),
		.second_num (second_num),
		.second_den (second_den),
		.stat       (stat),
		.res_num    (res_num),
		.res_den    (res_den),
		.differs    (differs),
		.status     (status)
	);

	// A result only follows a request in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// An accepted request makes the unit busy
	a_busy_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// Error results read as zero over one
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != rau_pkg::ST_OK)) |-> (res_num == '0 && res_den == 31'd1))
		else $error("error result is not 0/1");

	// A difference is only reported with a good status
	a_differs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && differs) |-> (status == rau_pkg::ST_OK && res_num == '0))
		else $error("differs set with error status or nonzero fraction");

endmodule

`default_nettype wire

@@ design/rau_ctrl.sv @@
// Sequencing state machine of the rational arithmetic unit.
// Depends on rau_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rau_pkg::dp_stat_t stat,
	output rau_pkg::dp_cmd_t       cmd,
	output logic                   busy,
	output logic                   done
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL0 = 4'd1;
	localparam logic [3:0] S_MUL1 = 4'd2;
	localparam logic [3:0] S_MUL2 = 4'd3;
	localparam logic [3:0] S_COMB = 4'd4;
	localparam logic [3:0] S_SIGN = 4'd5;
	localparam logic [3:0] S_GCD  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	localparam logic [rau_pkg::CNT_W-1:0] CNT_LAST = rau_pkg::CNT_W'(rau_pkg::WIDE - 1);

	logic [3:0]                state_q, state_d;
	logic [rau_pkg::CNT_W-1:0] cnt_q;
	logic                      done_q;

	// Decode the state into commands and the next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_MUL0;
				end
			end
			S_MUL0: begin
				if (stat.early_exit) begin
					state_d = S_FIN;
				end else begin
					cmd.mul_en   = 1'b1;
					cmd.mul_step = rau_pkg::MS_P;
					state_d      = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = rau_pkg::MS_Q;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = rau_pkg::MS_D;
				state_d      = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d  = stat.is_cmp ? S_FIN : S_SIGN;
			end
			S_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = stat.num_zero ? S_FIN : S_GCD;
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance the state, count division steps, raise the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

@@ design/rau_dp.sv @@
// Datapath of the rational arithmetic unit: shared multiplier, binary gcd,
// two parallel restoring dividers and the result registers. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_dp #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire rau_pkg::dp_cmd_t   cmd,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] first_num,
	input  wire logic [30:0]        first_den,
	input  wire logic signed [31:0] second_num,
	input  wire logic [30:0]        second_den,
	output rau_pkg::dp_stat_t       stat,
	output logic signed [31:0]      res_num,
	output logic [30:0]             res_den,
	output logic                    differs,
	output logic [1:0]              status
);

	localparam int W = rau_pkg::WIDE;
	localparam logic [W-1:0] LIM = (W'(1) << (WORD_BITS - 1)) - W'(1);

	// Latched request
	logic [2:0]         kind_q;
	logic signed [31:0] an_q, bn_q;
	logic [30:0]        ad_q, bd_q;

	// Products and working registers
	logic signed [W-1:0] p_q, q_q, d_q, num_q;
	logic                neg_q;
	logic [W-1:0]        nm_q, dm_q, u_q, v_q, rn_q, rd_q;

	// Result registers
	logic signed [31:0] res_num_q;
	logic [30:0]        res_den_q;
	logic               differs_q;
	logic [1:0]         status_q;

	logic kind_bad, den_zero, div_zero;

	logic signed [32:0]   mul_a, mul_b;
	logic signed [65:0]   prod;
	logic signed [W-1:0]  num_d;
	logic [W-1:0]         num_mag, den_mag;
	logic [W-1:0]         u_sub, v_sub;
	logic                 u_gt;
	logic [W-1:0]         rn_sh, rd_sh;
	logic                 rn_ge, rd_ge;
	logic                 ovf;
	logic [31:0]          qn_lo;

	// Outcome of the request, taken on finish
	logic signed [31:0] res_num_d;
	logic [30:0]        res_den_d;
	logic               differs_d;
	logic [1:0]         status_d;

	// Decode error cases from the latched request
	assign kind_bad = (kind_q > rau_pkg::K_NE);
	assign den_zero = (ad_q == '0) || ((kind_q != rau_pkg::K_NEG) && (bd_q == '0));
	assign div_zero = (kind_q == rau_pkg::K_DIV) && (bn_q == '0);

	assign stat.early_exit = kind_bad || den_zero || div_zero;
	assign stat.is_cmp     = (kind_q == rau_pkg::K_NE);
	assign stat.num_zero   = (num_q == '0);
	assign stat.gcd_done   = (u_q == v_q);

	// Select multiplier operands for each step
	always_comb begin
		case (cmd.mul_step)
			rau_pkg::MS_P: begin
				mul_a = {an_q[31], an_q};
				if (kind_q == rau_pkg::K_MUL) begin
					mul_b = {bn_q[31], bn_q};
				end else if (kind_q == rau_pkg::K_NEG) begin
					mul_b = '1;
				end else begin
					mul_b = {2'b00, bd_q};
				end
			end
			rau_pkg::MS_Q: begin
				mul_a = {bn_q[31], bn_q};
				mul_b = {2'b00, ad_q};
			end
			default: begin
				mul_a = {2'b00, ad_q};
				if (kind_q == rau_pkg::K_DIV) begin
					mul_b = {bn_q[31], bn_q};
				end else if (kind_q == rau_pkg::K_NEG) begin
					mul_b = 33'sd1;
				end else begin
					mul_b = {2'b00, bd_q};
				end
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Combine the cross products into the raw numerator
	always_comb begin
		case (kind_q) inside
			rau_pkg::K_ADD, rau_pkg::K_NE: num_d = p_q + q_q;
			rau_pkg::K_SUB:                num_d = p_q - q_q;
			default:                       num_d = p_q;
		endcase
	end

	assign num_mag = num_q[W-1] ? W'(-num_q) : W'(num_q);
	assign den_mag = d_q[W-1] ? W'(-d_q) : W'(d_q);

	// Binary gcd: subtract the smaller odd value, halve the difference
	assign u_gt  = (u_q > v_q);
	assign u_sub = u_q - v_q;
	assign v_sub = v_q - u_q;

	// Restoring division step for both quotients
	assign rn_sh = {rn_q[W-2:0], nm_q[W-1]};
	assign rd_sh = {rd_q[W-2:0], dm_q[W-1]};
	assign rn_ge = (rn_sh >= u_q);
	assign rd_ge = (rd_sh >= u_q);

	// Range check of the reduced fraction
	assign ovf   = (dm_q > LIM) || (nm_q > (neg_q ? LIM + W'(1) : LIM));
	assign qn_lo = nm_q[31:0];

	// Pick the outcome of the request
	always_comb begin
		res_num_d = '0;
		res_den_d = 31'd1;
		differs_d = 1'b0;
		status_d  = rau_pkg::ST_OK;
		if (kind_bad) begin
			status_d = rau_pkg::ST_OK;
		end else if (den_zero || div_zero) begin
			status_d = rau_pkg::ST_DIV_ZERO;
		end else if (kind_q == rau_pkg::K_NE) begin
			differs_d = (p_q != q_q);
		end else if (num_q == '0) begin
			status_d = rau_pkg::ST_OK;
		end else if (ovf) begin
			status_d = rau_pkg::ST_OVERFLOW;
		end else begin
			res_num_d = neg_q ? -qn_lo : qn_lo;
			res_den_d = dm_q[30:0];
		end
	end

	always_ff @(posedge clk) begin
		// Hold the request
		if (cmd.load) begin
			kind_q <= kind;
			an_q   <= first_num;
			ad_q   <= first_den;
			bn_q   <= second_num;
			bd_q   <= second_den;
		end

		// Store the product of this step
		if (cmd.mul_en) begin
			case (cmd.mul_step)
				rau_pkg::MS_P: p_q <= prod[W-1:0];
				rau_pkg::MS_Q: q_q <= prod[W-1:0];
				default:       d_q <= prod[W-1:0];
			endcase
		end

		if (cmd.comb) begin
			num_q <= num_d;
		end

		// Split off the sign and seed the gcd
		if (cmd.sign) begin
			neg_q <= num_q[W-1] ^ d_q[W-1];
			nm_q  <= num_mag;
			dm_q  <= den_mag;
			u_q   <= num_mag;
			v_q   <= den_mag;
		end

		// Binary gcd step; drop common factors of two from the dividends as well
		if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q  <= u_q >> 1;
				v_q  <= v_q >> 1;
				nm_q <= nm_q >> 1;
				dm_q <= dm_q >> 1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_gt) begin
				u_q <= u_sub >> 1;
			end else begin
				v_q <= v_sub >> 1;
			end
		end

		if (cmd.div_init) begin
			rn_q <= '0;
			rd_q <= '0;
		end

		// Shift dividends into remainders, quotient bits in from the right
		if (cmd.div_step) begin
			rn_q <= rn_ge ? rn_sh - u_q : rn_sh;
			rd_q <= rd_ge ? rd_sh - u_q : rd_sh;
			nm_q <= {nm_q[W-2:0], rn_ge};
			dm_q <= {dm_q[W-2:0], rd_ge};
		end

		// Capture the outcome
		if (cmd.finish) begin
			res_num_q <= res_num_d;
			res_den_q <= res_den_d;
			differs_q <= differs_d;
			status_q  <= status_d;
		end
	end

	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign differs = differs_q;
	assign status  = status_q;

endmodule

`default_nettype wire
